/* sv/ccc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccc_pkg: shared types and scan rule for the C source character classifier
// holds the class codes, scanner state and the per-byte classification step
// ----------------------------------------------------------------------------
package ccc_pkg;

    typedef enum logic [2:0] {
        CLS_SPACE   = 3'd0,
        CLS_TAB     = 3'd1,
        CLS_NEWLINE = 3'd2,
        CLS_COMMENT = 3'd3,
        CLS_STRING  = 3'd4,
        CLS_NUMBER  = 3'd5,
        CLS_IDENT   = 3'd6,
        CLS_OTHER   = 3'd7
    } class_t;

    typedef enum logic [1:0] {
        RUN_NONE  = 2'd0,
        RUN_DIGIT = 2'd1,
        RUN_IDENT = 2'd2
    } run_t;

    localparam logic [7:0] CH_SLASH     = 8'h2f;
    localparam logic [7:0] CH_STAR      = 8'h2a;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5c;
    localparam logic [7:0] CH_NEWLINE   = 8'h0a;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_UNDER     = 8'h5f;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [1:0] POS_FULL     = 2'd3;

    typedef struct packed {
        logic [7:0] back_one;
        logic [7:0] back_two;
        logic [7:0] back_three;
        logic [1:0] pos;
        logic       line_cmt;
        logic       block_cmt;
        logic       quote_par;
        run_t       run;
    } scan_state_t;

    typedef struct packed {
        scan_state_t st;
        class_t      cls;
    } step_res_t;

    typedef struct packed {
        logic [7:0] ch;
        class_t     cls;
        logic       fin;
    } result_t;

    function automatic logic is_dig(logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_idch(logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a], CH_UNDER};
    endfunction

    function automatic step_res_t classify(scan_state_t s, logic [7:0] c, logic [7:0] nxt);
        step_res_t r;
        logic      in_cmt;
        r.st   = s;
        r.cls  = CLS_OTHER;
        in_cmt = 1'b0;
        if (s.run == RUN_DIGIT && is_dig(c))
        begin
            r.cls = CLS_NUMBER;
        end
        else if (s.run == RUN_IDENT && is_idch(c))
        begin
            r.cls = CLS_IDENT;
        end
        else
        begin
            r.st.run = RUN_NONE;
            if (c == CH_SLASH && nxt == CH_SLASH)
                r.st.line_cmt = 1'b1;
            if (s.pos == POS_FULL && s.back_one == CH_SLASH && s.back_two == CH_STAR
                && s.back_three != CH_SLASH)
                r.st.block_cmt = 1'b0;
            if (c == CH_SLASH && nxt == CH_STAR)
                r.st.block_cmt = 1'b1;
            in_cmt = r.st.line_cmt || r.st.block_cmt;
            if (!in_cmt && c == CH_QUOTE && (s.pos == 2'd0 || s.back_one != CH_BACKSLASH))
                r.st.quote_par = ~s.quote_par;
            if (c == CH_NEWLINE)
            begin
                r.cls         = CLS_NEWLINE;
                r.st.line_cmt = 1'b0;
            end
            else if (c == CH_TAB)
                r.cls = CLS_TAB;
            else if (c == CH_SPACE)
                r.cls = CLS_SPACE;
            else if (in_cmt)
                r.cls = CLS_COMMENT;
            else if (r.st.quote_par || c == CH_QUOTE)
                r.cls = CLS_STRING;
            else if (is_dig(c))
            begin
                r.cls    = CLS_NUMBER;
                r.st.run = RUN_DIGIT;
            end
            else if (is_idch(c))
            begin
                r.cls    = CLS_IDENT;
                r.st.run = RUN_IDENT;
            end
            else
                r.cls = CLS_OTHER;
        end
        r.st.back_three = s.back_two;
        r.st.back_two   = s.back_one;
        r.st.back_one   = c;
        if (s.pos != POS_FULL)
            r.st.pos = s.pos + 2'd1;
        return r;
    endfunction

endpackage
`default_nettype wire

/* sv/ccc_outq.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccc_outq: result queue
// small register queue that takes up to two results per cycle in order
// and hands one result per cycle to the output channel in each cycle that
// pop is high
module ccc_outq
    import ccc_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [1:0]                 push_cnt,
    input  wire result_t                    push_a,
    input  wire result_t                    push_b,
    input  wire logic                       pop,
    output result_t                         head,
    output logic [$clog2(DEPTH + 1) - 1:0]  count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    result_t         mem_reg [DEPTH];
    logic [PW - 1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW - 1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW - 1:0] count_reg, count_next;
    logic [PW - 1:0] wr_ptr_b;

    function automatic logic [PW - 1:0] ptr_inc(logic [PW - 1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign wr_ptr_b = ptr_inc(wr_ptr_reg);
    assign head     = mem_reg[rd_ptr_reg];
    assign count    = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        case (push_cnt)
            2'd1:    wr_ptr_next = wr_ptr_b;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_b);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        if (pop)
            rd_ptr_next = ptr_inc(rd_ptr_reg);
        count_next = count_reg + CW'(push_cnt) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            mem_reg[wr_ptr_reg] <= push_a;
        if (push_cnt == 2'd2)
            mem_reg[wr_ptr_b] <= push_b;
    end

endmodule
`default_nettype wire

/* sv/c_source_char_classifier.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c_source_char_classifier: highlight class for each byte of C source text
// holds one byte back for lookahead, tracks comment, string and run state,
// and queues the classified bytes for the output channel
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid / in_ready  | char_byte, last_byte
//  out     | out_valid / out_ready| out_byte, char_class, is_final
//
// one input transaction per cycle while in_ready is high; the held byte is
// classified and queued in the cycle its successor is accepted.
// a final byte after a held byte gives two results, both queued in the same cycle.
// in_ready drops only when the result queue has fewer than two free slots.
// reset clears all scan state and empties the queue.
// ----------------------------------------------------------------------------
module c_source_char_classifier
    import ccc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] char_byte,
    input  wire logic       last_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic [2:0]      char_class,
    output logic            is_final
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    scan_state_t     state_reg, state_next;
    logic [7:0]      held_char_reg, held_char_next;
    logic            held_valid_reg, held_valid_next;
    step_res_t       held_step;
    step_res_t       last_step;
    scan_state_t     mid_state;
    result_t         push_a;
    result_t         push_b;
    logic [1:0]      push_cnt;
    logic            accept;
    logic            pop;
    result_t         head;
    logic [CW - 1:0] q_count;

    assign in_ready = (q_count <= CW'(QUEUE_DEPTH - 2));
    assign accept   = in_valid && in_ready;
    assign out_valid = (q_count != '0);
    assign pop       = out_valid && out_ready;

    assign out_byte   = head.ch;
    assign char_class = head.cls;
    assign is_final   = head.fin;

    always_comb
    begin
        held_step = classify(state_reg, held_char_reg, char_byte);
        mid_state = held_valid_reg ? held_step.st : state_reg;
        last_step = classify(mid_state, char_byte, 8'h00);

        push_b.ch  = char_byte;
        push_b.cls = last_step.cls;
        push_b.fin = 1'b1;
        if (held_valid_reg)
        begin
            push_a.ch  = held_char_reg;
            push_a.cls = held_step.cls;
            push_a.fin = 1'b0;
        end
        else
            push_a = push_b;

        push_cnt        = 2'd0;
        state_next      = state_reg;
        held_char_next  = held_char_reg;
        held_valid_next = held_valid_reg;
        if (accept)
        begin
            push_cnt = {1'b0, held_valid_reg} + {1'b0, last_byte};
            if (last_byte)
            begin
                state_next      = '0;
                held_char_next  = '0;
                held_valid_next = 1'b0;
            end
            else
            begin
                state_next      = mid_state;
                held_char_next  = char_byte;
                held_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= '0;
            held_char_reg  <= '0;
            held_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            held_char_reg  <= held_char_next;
            held_valid_reg <= held_valid_next;
        end
    end

    ccc_outq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_cnt (push_cnt),
        .push_a   (push_a),
        .push_b   (push_b),
        .pop      (pop),
        .head     (head),
        .count    (q_count)
    );

endmodule
`default_nettype wire

/* bench/ccc_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccc_result_checker: scoreboard for the C source character classifier
// watches both channels, keeps its own copy of the scanner state, works out
// the highlight class of every byte as input transactions are accepted and
// compares each output transaction field by field with the oldest prediction
// ----------------------------------------------------------------------------
module ccc_result_checker
    import ccc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] char_byte,
    input  logic       last_byte,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] out_byte,
    input  logic [2:0] char_class,
    input  logic       is_final,
    output int         fail_count,
    output int         pending
);

    localparam int REPORT_MAX = 10;

    // predicted scanner state
    logic [7:0] pend_char;
    logic       pend_ok;
    logic [7:0] hist1;
    logic [7:0] hist2;
    logic [7:0] hist3;
    logic [1:0] seen_cnt;
    logic       in_line_cmt;
    logic       in_block_cmt;
    logic       str_odd;
    run_t       cur_run;

    result_t    expected_q[$];
    int         errs;

    function automatic void clear_scan();
        pend_char    = 8'h00;
        pend_ok      = 1'b0;
        hist1        = 8'h00;
        hist2        = 8'h00;
        hist3        = 8'h00;
        seen_cnt     = 2'd0;
        in_line_cmt  = 1'b0;
        in_block_cmt = 1'b0;
        str_odd      = 1'b0;
        cur_run      = RUN_NONE;
    endfunction

    // class of one byte given the byte after it; advances the scanner state
    function automatic class_t grade_byte(input logic [7:0] ch, input logic [7:0] follow);
        class_t cls;
        logic   cmt;
        logic   dig;
        logic   word;
        dig  = (ch >= 8'h30) && (ch <= 8'h39);
        word = dig || ((ch >= 8'h41) && (ch <= 8'h5a)) || ((ch >= 8'h61) && (ch <= 8'h7a))
               || (ch == CH_UNDER);
        cls  = CLS_OTHER;
        if (cur_run == RUN_DIGIT && dig)
        begin
            cls = CLS_NUMBER;
        end
        else if (cur_run == RUN_IDENT && word)
        begin
            cls = CLS_IDENT;
        end
        else
        begin
            cur_run = RUN_NONE;
            if (ch == CH_SLASH && follow == CH_SLASH)
                in_line_cmt = 1'b1;
            // close of a block comment, but not the slash-star-slash case
            if (seen_cnt == POS_FULL && hist1 == CH_SLASH && hist2 == CH_STAR
                && hist3 != CH_SLASH)
                in_block_cmt = 1'b0;
            if (ch == CH_SLASH && follow == CH_STAR)
                in_block_cmt = 1'b1;
            cmt = in_line_cmt | in_block_cmt;
            if (!cmt && ch == CH_QUOTE && (seen_cnt == 2'd0 || hist1 != CH_BACKSLASH))
                str_odd = ~str_odd;
            if (ch == CH_NEWLINE)
            begin
                cls         = CLS_NEWLINE;
                in_line_cmt = 1'b0;
            end
            else if (ch == CH_TAB)
                cls = CLS_TAB;
            else if (ch == CH_SPACE)
                cls = CLS_SPACE;
            else if (cmt)
                cls = CLS_COMMENT;
            else if (str_odd || ch == CH_QUOTE)
                cls = CLS_STRING;
            else if (dig)
            begin
                cls     = CLS_NUMBER;
                cur_run = RUN_DIGIT;
            end
            else if (word)
            begin
                cls     = CLS_IDENT;
                cur_run = RUN_IDENT;
            end
        end
        hist3 = hist2;
        hist2 = hist1;
        hist1 = ch;
        if (seen_cnt != POS_FULL)
            seen_cnt = seen_cnt + 2'd1;
        return cls;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            clear_scan();
            expected_q.delete();
            errs       = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (pend_ok)
                begin
                    want.ch  = pend_char;
                    want.cls = grade_byte(pend_char, char_byte);
                    want.fin = 1'b0;
                    expected_q.push_back(want);
                end
                if (last_byte)
                begin
                    want.ch  = char_byte;
                    want.cls = grade_byte(char_byte, 8'h00);
                    want.fin = 1'b1;
                    expected_q.push_back(want);
                    clear_scan();
                end
                else
                begin
                    pend_char = char_byte;
                    pend_ok   = 1'b1;
                end
            end
            if (out_valid && out_ready)
            begin
                got.ch  = out_byte;
                got.cls = class_t'(char_class);
                got.fin = is_final;
                if (expected_q.size() == 0)
                begin
                    errs = errs + 1;
                    if (errs <= REPORT_MAX)
                        $display("unexpected transaction: byte %02h class %0d final %0b",
                                 got.ch, got.cls, got.fin);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.ch !== want.ch || got.cls !== want.cls || got.fin !== want.fin)
                    begin
                        errs = errs + 1;
                        if (errs <= REPORT_MAX)
                            $display({"mismatch: exp byte %02h class %0d final %0b, ",
                                      "got byte %02h class %0d final %0b"},
                                     want.ch, want.cls, want.fin,
                                     got.ch, got.cls, got.fin);
                    end
                end
            end
            fail_count <= errs;
            pending    <= expected_q.size();
        end
    end

endmodule

/* bench/tb_c_source_char_classifier.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_c_source_char_classifier: testbench for the C source character classifier
// feeds directed snippets and random C-like texts with random idling on both
// channels, a long output stall and a drain pause; a separate checker
// predicts every class and the top reports the verdict
// ----------------------------------------------------------------------------
module tb_c_source_char_classifier;
    import ccc_pkg::*;

    localparam int ITEM_TARGET = 700;
    localparam int QUIET_FROM  = 620;
    localparam int HOLD_AT     = 150;
    localparam int HOLD_CYCLES = 60;
    localparam int PAUSE_AT    = 400;
    localparam int IDLE_LIMIT  = 2000;
    localparam int TAIL_CYCLES = 20;

    typedef enum int {
        TK_IDENT,
        TK_NUMBER,
        TK_BLANK,
        TK_LINE_CMT,
        TK_BLOCK_OPEN,
        TK_BLOCK_CLOSE,
        TK_SLASH_STAR_SLASH,
        TK_QUOTE,
        TK_ESC_QUOTE,
        TK_PRINTABLE,
        TK_ANY_BYTE,
        TK_COUNT
    } token_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] char_byte;
    logic       last_byte;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_byte;
    logic [2:0] char_class;
    logic       is_final;
    int         fail_count;
    int         pending;

    int         items_sent;
    bit         quiet;
    bit         hold_go;
    bit         hold_done;
    int         idle_cycles;
    logic [7:0] text_buf[$];

    c_source_char_classifier uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .char_byte  (char_byte),
        .last_byte  (last_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .char_class (char_class),
        .is_final   (is_final)
    );

    ccc_result_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .char_byte  (char_byte),
        .last_byte  (last_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .char_class (char_class),
        .is_final   (is_final),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // receiver: random stalls, one long hold-off
    initial
    begin
        out_ready = 1'b0;
        hold_done = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_go && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
                out_ready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic fin);
        in_valid  <= 1'b1;
        char_byte <= b;
        last_byte <= fin;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent = items_sent + 1;
    endtask

    task automatic sender_gap();
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i], i == s.len() - 1);
            sender_gap();
        end
    endtask

    function automatic logic [7:0] word_char(input bit first);
        int r;
        r = first ? int'($urandom_range(0, 52)) : int'($urandom_range(0, 62));
        if (r < 26)
            return 8'(8'h61 + r);
        else if (r < 52)
            return 8'(8'h41 + (r - 26));
        else if (r == 52)
            return CH_UNDER;
        else
            return 8'(8'h30 + (r - 53));
    endfunction

    task automatic add_token(input token_t kind);
        int n;
        case (kind)
            TK_IDENT:
            begin
                n = $urandom_range(0, 5);
                text_buf.push_back(word_char(1'b1));
                repeat (n) text_buf.push_back(word_char(1'b0));
            end
            TK_NUMBER:
            begin
                n = $urandom_range(1, 4);
                repeat (n) text_buf.push_back(8'(8'h30 + $urandom_range(0, 9)));
            end
            TK_BLANK:
            begin
                n = $urandom_range(0, 2);
                text_buf.push_back(n == 0 ? CH_SPACE : (n == 1 ? CH_TAB : CH_NEWLINE));
            end
            TK_LINE_CMT:
            begin
                text_buf.push_back(CH_SLASH);
                text_buf.push_back(CH_SLASH);
            end
            TK_BLOCK_OPEN:
            begin
                text_buf.push_back(CH_SLASH);
                text_buf.push_back(CH_STAR);
            end
            TK_BLOCK_CLOSE:
            begin
                text_buf.push_back(CH_STAR);
                text_buf.push_back(CH_SLASH);
            end
            TK_SLASH_STAR_SLASH:
            begin
                text_buf.push_back(CH_SLASH);
                text_buf.push_back(CH_STAR);
                text_buf.push_back(CH_SLASH);
            end
            TK_QUOTE:
                text_buf.push_back(CH_QUOTE);
            TK_ESC_QUOTE:
            begin
                text_buf.push_back(CH_BACKSLASH);
                text_buf.push_back(CH_QUOTE);
            end
            TK_PRINTABLE:
                text_buf.push_back(8'($urandom_range(8'h20, 8'h7e)));
            default:
                text_buf.push_back(8'($urandom_range(0, 255)));
        endcase
    endtask

    task automatic send_buf(input bit mark_end);
        for (int i = 0; i < text_buf.size(); i++)
        begin
            send_byte(text_buf[i], mark_end && (i == text_buf.size() - 1));
            if (items_sent >= HOLD_AT)
                hold_go = 1'b1;
            if (items_sent >= QUIET_FROM)
                quiet = 1'b1;
            sender_gap();
        end
        text_buf.delete();
    endtask

    initial
    begin
        int ntok;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        char_byte  = 8'h00;
        last_byte  = 1'b0;
        items_sent = 0;
        quiet      = 1'b0;
        hold_go    = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes of the byte, final byte with nothing held
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hff, 1'b1);
        send_byte(8'hff, 1'b1);
        // runs, blanks, comments, escaped quote, slash-star-slash
        send_text("x1 9_\t\n");
        send_text("//c\n");
        send_text("\"\\\"\"");
        send_text("/*/x*/");

        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= PAUSE_AT && items_sent < PAUSE_AT + 40)
            begin
                // let every expected result drain before going on
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (pending != 0);
            end
            if ($urandom_range(0, 6) == 0)
            begin
                ntok = $urandom_range(1, 10);
                repeat (ntok) add_token(TK_ANY_BYTE);
                send_buf(1'($urandom_range(0, 1)));
            end
            else
            begin
                ntok = $urandom_range(1, 10);
                repeat (ntok) add_token(token_t'($urandom_range(0, TK_COUNT - 1)));
                send_buf(1'b1);
            end
        end
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        in_valid <= 1'b0;

        do
            @(posedge clk);
        while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
